// ===== design/assert_macros.svh =====
// assertion helpers for the design files, included by scs_core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("assertion failed");
`else
`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

// ===== design/scs_pkg.sv =====
`default_nettype none
package scs_pkg;

   localparam int SAMPLE_W    = 12;
   localparam int SAMPLE_BITS = 12;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((1 << SAMPLE_BITS) - 1);

   localparam int MIX_W   = 16;
   localparam int PROD_W  = 32;
   // n / 10 == (n * 52429) >> 19 for every 16-bit n
   localparam logic [MIX_W-1:0] RECIP_TEN = 16'd52429;
   localparam int RECIP_SHIFT = 19;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] REG_HIGH_THR = 2'd0;
   localparam logic [1:0] REG_LOW_THR  = 2'd1;
   localparam logic [1:0] REG_INTERVAL = 2'd2;

   localparam logic [11:0] HIGH_THR_RESET = 12'd300;
   localparam logic [11:0] LOW_THR_RESET  = 12'd300;
   localparam logic [15:0] INTERVAL_RESET = 16'd5000;

   typedef enum logic [1:0] {
      LEVEL_NORMAL = 2'd0,
      LEVEL_LOW    = 2'd1,
      LEVEL_HIGH   = 2'd2
   } level_type;

   typedef struct packed {
      logic [11:0] high_thr;
      logic [11:0] low_thr;
      logic [15:0] interval;
   } cfg_type;

endpackage
`default_nettype wire

// ===== design/scs_channels.sv =====
`default_nettype none
interface scs_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic [11:0] gsr_sample;
   logic [31:0] now_ms;

   modport source (output valid, output func, output gsr_sample, output now_ms,
                   input ready);
   modport sink (input valid, input func, input gsr_sample, input now_ms,
                 output ready);
endinterface

interface scs_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  stress_level;
   logic [11:0] filtered_level;
   logic [11:0] baseline_level;
   logic        baseline_ready;

   modport source (output valid, output stress_level, output filtered_level,
                   output baseline_level, output baseline_ready, input ready);
   modport sink (input valid, input stress_level, input filtered_level,
                 input baseline_level, input baseline_ready, output ready);
endinterface
`default_nettype wire

// ===== design/scs_csr.sv =====
`default_nettype none
module scs_csr
   import scs_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready,
   output cfg_type                    cfg
);

   cfg_type    cfg_ff;
   logic [1:0] reg_idx;
   logic       wr_en;

   assign reg_idx = paddr[CSR_ADDR_W-1:2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.high_thr <= HIGH_THR_RESET;
         cfg_ff.low_thr  <= LOW_THR_RESET;
         cfg_ff.interval <= INTERVAL_RESET;
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_HIGH_THR: cfg_ff.high_thr <= pwdata[11:0];
            REG_LOW_THR:  cfg_ff.low_thr  <= pwdata[11:0];
            REG_INTERVAL: cfg_ff.interval <= pwdata[15:0];
            default:      ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_HIGH_THR: prdata = {20'd0, cfg_ff.high_thr};
         REG_LOW_THR:  prdata = {20'd0, cfg_ff.low_thr};
         REG_INTERVAL: prdata = {16'd0, cfg_ff.interval};
         default:      prdata = '0;
      endcase
   end

endmodule
`default_nettype wire

// ===== design/scs_div.sv =====
`default_nettype none
module scs_div #(
   parameter int NUM_W = 18,
   parameter int DEN_W = 6
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output logic                  busy,
   output logic                  done,
   output logic      [NUM_W-1:0] quot
);

   localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [NUM_W-1:0] num_ff;
   logic [DEN_W-1:0] den_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;
   logic             ge;
   logic [DEN_W-1:0] rem_in;

   // restoring division, one quotient bit per cycle
   always_comb begin
      trial  = {rem_ff, num_ff[NUM_W-1]};
      diff   = trial - {1'b0, den_ff};
      ge     = (trial >= {1'b0, den_ff});
      rem_in = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            num_ff  <= num;
            den_ff  <= den;
            rem_ff  <= '0;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            num_ff <= {num_ff[NUM_W-2:0], ge};
            rem_ff <= rem_in;
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(NUM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quot = num_ff;

endmodule
`default_nettype wire

// ===== design/scs_core.sv =====
`default_nettype none
`include "assert_macros.svh"
module scs_core
   import scs_pkg::*;
#(
   parameter int WINDOW_LEN  = 10,
   parameter int CAL_SAMPLES = 50,
   parameter int NUM_W       = 18,
   parameter int DEN_W       = 6
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  cfg_type               cfg,
   scs_req_if.sink               req,
   scs_rsp_if.source             rsp,
   output logic                  div_start,
   output logic      [NUM_W-1:0] div_num,
   output logic      [DEN_W-1:0] div_den,
   input  wire logic             div_busy,
   input  wire logic             div_done,
   input  wire logic [NUM_W-1:0] div_quot
);

   localparam int SUM_W = SAMPLE_W + $clog2(WINDOW_LEN + 1);
   localparam int CAL_W = SAMPLE_W + $clog2(CAL_SAMPLES + 1);
   localparam int IDX_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
   localparam int CNT_W = $clog2(CAL_SAMPLES + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_WIN, S_MEAN, S_UPD, S_MUL, S_BASE, S_CLASS, S_CAL, S_CALDIV, S_OUT
   } state_type;

   state_type         state_ff;
   logic [SAMPLE_W-1:0] sample_ff;
   logic [31:0]       now_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic              full_ff;
   logic [SUM_W-1:0]  sum_ff;
   logic [11:0]       base_ff;
   logic              ready_ff;
   logic [31:0]       last_ff;
   logic [CAL_W-1:0]  cal_sum_ff;
   logic [CNT_W-1:0]  cal_cnt_ff;
   logic [11:0]       mean_ff;
   level_type         level_ff;
   logic [MIX_W-1:0]  mix_ff;
   logic [PROD_W-1:0] prod_ff;
   logic              rsp_valid_ff;
   logic [1:0]        rsp_level_ff;
   logic [11:0]       rsp_mean_ff;
   logic [11:0]       rsp_base_ff;
   logic              rsp_ready_flag_ff;

   logic [SAMPLE_W-1:0] win_mem [WINDOW_LEN];
   logic [SAMPLE_W-1:0] rd_data_ff;
   logic                win_we;

   logic [SAMPLE_W-1:0] old_sample;
   logic [SUM_W-1:0]  sum_in;
   logic [IDX_W-1:0]  idx_in;
   logic              full_in;
   logic [DEN_W-1:0]  held_in;
   logic [CAL_W-1:0]  cal_sum_in;
   logic [CNT_W-1:0]  cal_cnt_in;
   logic              cal_last;
   logic [31:0]       elapsed;
   logic              upd_due;
   logic signed [12:0] diff;
   logic signed [12:0] high_lim;
   logic signed [12:0] low_lim;
   logic              rsp_load;
   logic              accept;

   assign req.ready = (state_ff == S_IDLE);
   assign accept    = req.valid && (state_ff == S_IDLE);

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.stress_level   = rsp_level_ff;
   assign rsp.filtered_level = rsp_mean_ff;
   assign rsp.baseline_level = rsp_base_ff;
   assign rsp.baseline_ready = rsp_ready_flag_ff;
   assign rsp_load = (state_ff == S_OUT) && (!rsp_valid_ff || rsp.ready);

   // entries past the write pointer are unwritten until the window first fills
   always_comb begin
      old_sample = full_ff ? rd_data_ff : '0;
      sum_in     = sum_ff - SUM_W'(old_sample) + SUM_W'(sample_ff);
      if (idx_ff == IDX_W'(WINDOW_LEN - 1)) begin
         idx_in  = '0;
         full_in = 1'b1;
      end else begin
         idx_in  = idx_ff + 1'b1;
         full_in = full_ff;
      end
      held_in = full_in ? DEN_W'(WINDOW_LEN) : DEN_W'(idx_in);

      cal_sum_in = cal_sum_ff + CAL_W'(sample_ff);
      cal_cnt_in = cal_cnt_ff + 1'b1;
      cal_last   = (cal_cnt_in >= CNT_W'(CAL_SAMPLES));

      elapsed = now_ff - last_ff;
      upd_due = (elapsed >= {16'd0, cfg.interval});

      diff     = $signed({1'b0, mean_ff}) - $signed({1'b0, base_ff});
      high_lim = $signed({1'b0, cfg.high_thr});
      low_lim  = 13'sd0 - $signed({1'b0, cfg.low_thr});
   end

   always_comb begin
      div_start = 1'b0;
      div_num   = NUM_W'(sum_in);
      div_den   = held_in;
      if (state_ff == S_WIN) begin
         div_start = 1'b1;
      end else if ((state_ff == S_CAL) && !ready_ff && cal_last) begin
         div_start = 1'b1;
         div_num   = NUM_W'(cal_sum_in);
         div_den   = DEN_W'(CAL_SAMPLES);
      end
   end

   assign win_we = (state_ff == S_WIN);

   always_ff @(posedge clock) begin
      if (win_we) begin
         win_mem[idx_ff] <= sample_ff;
      end
      rd_data_ff <= win_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         full_ff      <= 1'b0;
         sum_ff       <= '0;
         base_ff      <= '0;
         ready_ff     <= 1'b0;
         last_ff      <= '0;
         cal_sum_ff   <= '0;
         cal_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  sample_ff <= req.gsr_sample & SAMPLE_MASK;
                  now_ff    <= req.now_ms;
                  mean_ff   <= '0;
                  level_ff  <= LEVEL_NORMAL;
                  state_ff  <= req.func ? S_WIN : S_CAL;
               end
            end
            S_WIN: begin
               sum_ff   <= sum_in;
               idx_ff   <= idx_in;
               full_ff  <= full_in;
               state_ff <= S_MEAN;
            end
            S_MEAN: begin
               if (div_done) begin
                  mean_ff  <= div_quot[11:0];
                  state_ff <= ready_ff ? S_UPD : S_OUT;
               end
            end
            S_UPD: begin
               mix_ff   <= MIX_W'({base_ff, 3'd0}) + MIX_W'(base_ff) + MIX_W'(mean_ff);
               state_ff <= upd_due ? S_MUL : S_CLASS;
            end
            S_MUL: begin
               prod_ff  <= PROD_W'(mix_ff) * PROD_W'(RECIP_TEN);
               state_ff <= S_BASE;
            end
            S_BASE: begin
               base_ff  <= prod_ff[RECIP_SHIFT +: 12];
               last_ff  <= now_ff;
               state_ff <= S_CLASS;
            end
            S_CLASS: begin
               priority if (diff > high_lim) begin
                  level_ff <= LEVEL_HIGH;
               end else if (diff < low_lim) begin
                  level_ff <= LEVEL_LOW;
               end else begin
                  level_ff <= LEVEL_NORMAL;
               end
               state_ff <= S_OUT;
            end
            S_CAL: begin
               if (!ready_ff) begin
                  cal_sum_ff <= cal_sum_in;
                  cal_cnt_ff <= cal_cnt_in;
                  state_ff   <= cal_last ? S_CALDIV : S_OUT;
               end else begin
                  state_ff <= S_OUT;
               end
            end
            S_CALDIV: begin
               if (div_done) begin
                  base_ff  <= div_quot[11:0];
                  ready_ff <= 1'b1;
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (rsp_load) begin
                  rsp_level_ff      <= level_ff;
                  rsp_mean_ff       <= mean_ff;
                  rsp_base_ff       <= base_ff;
                  rsp_ready_flag_ff <= ready_ff;
                  state_ff          <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   `ASSERT_PROP(a_idx_range, clock, reset, idx_ff <= IDX_W'(WINDOW_LEN - 1))
   `ASSERT_NEVER(a_ready_sticky, clock, reset, $fell(ready_ff))
   `ASSERT_NEVER(a_full_sticky, clock, reset, $fell(full_ff))
   `ASSERT_PROP(a_div_idle, clock, reset, div_start |-> !div_busy)
   `ASSERT_PROP(a_cal_bound, clock, reset, cal_cnt_ff <= CNT_W'(CAL_SAMPLES))

endmodule
`default_nettype wire

// ===== design/skin_conductance_stress_classifier.sv =====
`default_nettype none
// Skin-conductance stress classifier. Calibration transactions (func 0) accumulate a
// baseline that becomes their truncated mean after CAL_SAMPLES of them; measurement
// transactions (func 1) enter a WINDOW_LEN-entry moving window held in a one-port
// synchronous memory, and once the baseline is ready they move it toward the window
// mean at most once per update_interval_ms and class the mean against the thresholds.
// Every transaction returns exactly one result. The block handles one transaction at
// a time: a calibration transaction accumulates its sample and goes to the output, and
// the one that completes the baseline first waits for the divider; a measurement
// transaction writes the window and waits for the divider's mean, and once the baseline
// is ready also passes the update and class states, with a multiply and a baseline
// write when the baseline moves. NUM_W = 12 + clog2(max(WINDOW_LEN, CAL_SAMPLES) + 1)
// is the iteration count of the shared bit-serial divider (18 at the default parameters).
// A finished result waits in an output register while the next transaction is taken;
// a result that finds that register still full waits until the sink takes the older
// one. Registers sit at byte addresses 0 (high threshold), 4 (low threshold) and
// 8 (update interval).
module skin_conductance_stress_classifier
   import scs_pkg::*;
#(
   parameter int WINDOW_LEN  = 10,
   parameter int CAL_SAMPLES = 50
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   scs_req_if.sink                    req_bus,
   scs_rsp_if.source                  rsp_bus,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   localparam int SUM_W   = SAMPLE_W + $clog2(WINDOW_LEN + 1);
   localparam int CAL_W   = SAMPLE_W + $clog2(CAL_SAMPLES + 1);
   localparam int NUM_W   = (SUM_W > CAL_W) ? SUM_W : CAL_W;
   localparam int DEN_MAX = (WINDOW_LEN > CAL_SAMPLES) ? WINDOW_LEN : CAL_SAMPLES;
   localparam int DEN_W   = $clog2(DEN_MAX + 1);

   cfg_type          cfg;
   logic             div_start;
   logic [NUM_W-1:0] div_num;
   logic [DEN_W-1:0] div_den;
   logic             div_busy;
   logic             div_done;
   logic [NUM_W-1:0] div_quot;

   scs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   scs_div #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .done  (div_done),
      .quot  (div_quot)
   );

   scs_core #(
      .WINDOW_LEN  (WINDOW_LEN),
      .CAL_SAMPLES (CAL_SAMPLES),
      .NUM_W       (NUM_W),
      .DEN_W       (DEN_W)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req       (req_bus),
      .rsp       (rsp_bus),
      .div_start (div_start),
      .div_num   (div_num),
      .div_den   (div_den),
      .div_busy  (div_busy),
      .div_done  (div_done),
      .div_quot  (div_quot)
   );

endmodule
`default_nettype wire
